// File: hw/rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg - shared constants for the segment intersection block
// Field width of the ports, default coordinate width and queue depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssi_pkg;

  localparam int FIELD_W        = 31;
  localparam int COORD_BITS_DEF = 31;
  localparam int QUEUE_DEPTH    = 2;

endpackage

// File: hw/rtl/ssi_in_if.sv
// ----------------------------------------------------------------------------
// ssi_in_if - segment pair channel
// Valid/ready channel carrying the endpoints of two segments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssi_in_if import ssi_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] first_start_x;
  logic signed [FIELD_W-1:0] first_start_y;
  logic signed [FIELD_W-1:0] first_end_x;
  logic signed [FIELD_W-1:0] first_end_y;
  logic signed [FIELD_W-1:0] second_start_x;
  logic signed [FIELD_W-1:0] second_start_y;
  logic signed [FIELD_W-1:0] second_end_x;
  logic signed [FIELD_W-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );

  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );

endinterface

// File: hw/rtl/ssi_out_if.sv
// ----------------------------------------------------------------------------
// ssi_out_if - intersection result channel
// Valid/ready channel carrying the hit flag and the crossing point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssi_out_if import ssi_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [FIELD_W-1:0] cross_x;
  logic signed [FIELD_W-1:0] cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink   (input valid, hit, cross_x, cross_y, output ready);

endinterface

// File: hw/rtl/ssi_queue.sv
// ----------------------------------------------------------------------------
// ssi_queue - short word queue between front and back
// Register FIFO that lets the two halves stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssi_queue import ssi_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [0:DEPTH-1];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CNTW-1:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/ssi_front.sv
// ----------------------------------------------------------------------------
// ssi_front - accept and classify segment pairs
// Differences, cross products and the exact parameter range test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssi_front import ssi_pkg::*; #(
  parameter int W  = COORD_BITS_DEF,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  ssi_in_if.sink        pair,
  output logic          q_valid,
  output logic [DW-1:0] q_data,
  input  logic          q_ready
);

  localparam int CW = 2 * W + 2;
  localparam int MW = CW - 1;

  logic v0, v1, v2, v3;
  logic en;

  logic signed [W-1:0] ax_i, ay_i, bx_i, by_i, cx_i, cy_i, ex_i, ey_i;

  logic signed [W:0]   s0_v1x, s0_v1y, s0_v2x, s0_v2y, s0_wx, s0_wy;
  logic signed [W-1:0] s0_ax, s0_ay;

  logic signed [CW-1:0] s1_da, s1_db, s1_naa, s1_nab, s1_nba, s1_nbb;
  logic signed [W:0]    s1_v1x, s1_v1y;
  logic signed [W-1:0]  s1_ax, s1_ay;

  logic signed [CW-1:0] s2_den, s2_na, s2_nb;
  logic signed [W:0]    s2_v1x, s2_v1y;
  logic signed [W-1:0]  s2_ax, s2_ay;

  logic signed [CW-1:0] den_abs, na_n, nb_n;
  logic signed [W:0]    v1x_abs, v1y_abs;
  logic                 hit_c;

  logic                s3_hit;
  logic [MW-1:0]       s3_dn, s3_na;
  logic [W-1:0]        s3_mx, s3_my;
  logic                s3_nx, s3_ny;
  logic signed [W-1:0] s3_ax, s3_ay;

  assign en         = !v3 || q_ready;
  assign pair.ready = en;

  assign ax_i = pair.first_start_x[W-1:0];
  assign ay_i = pair.first_start_y[W-1:0];
  assign bx_i = pair.first_end_x[W-1:0];
  assign by_i = pair.first_end_y[W-1:0];
  assign cx_i = pair.second_start_x[W-1:0];
  assign cy_i = pair.second_start_y[W-1:0];
  assign ex_i = pair.second_end_x[W-1:0];
  assign ey_i = pair.second_end_y[W-1:0];

  always_comb begin
    den_abs = s2_den[CW-1] ? -s2_den : s2_den;
    na_n    = s2_den[CW-1] ? -s2_na  : s2_na;
    nb_n    = s2_den[CW-1] ? -s2_nb  : s2_nb;
    v1x_abs = s2_v1x[W] ? -s2_v1x : s2_v1x;
    v1y_abs = s2_v1y[W] ? -s2_v1y : s2_v1y;
    hit_c   = (s2_den != '0) && !na_n[CW-1] && !nb_n[CW-1] &&
              (na_n <= den_abs) && (nb_n <= den_abs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= pair.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_v1x <= (W+1)'(bx_i) - (W+1)'(ax_i);
      s0_v1y <= (W+1)'(by_i) - (W+1)'(ay_i);
      s0_v2x <= (W+1)'(ex_i) - (W+1)'(cx_i);
      s0_v2y <= (W+1)'(ey_i) - (W+1)'(cy_i);
      s0_wx  <= (W+1)'(ax_i) - (W+1)'(cx_i);
      s0_wy  <= (W+1)'(ay_i) - (W+1)'(cy_i);
      s0_ax  <= ax_i;
      s0_ay  <= ay_i;

      s1_da  <= CW'(s0_v1x) * CW'(s0_v2y);
      s1_db  <= CW'(s0_v1y) * CW'(s0_v2x);
      s1_naa <= CW'(s0_v2x) * CW'(s0_wy);
      s1_nab <= CW'(s0_v2y) * CW'(s0_wx);
      s1_nba <= CW'(s0_v1x) * CW'(s0_wy);
      s1_nbb <= CW'(s0_v1y) * CW'(s0_wx);
      s1_v1x <= s0_v1x;
      s1_v1y <= s0_v1y;
      s1_ax  <= s0_ax;
      s1_ay  <= s0_ay;

      s2_den <= s1_da - s1_db;
      s2_na  <= s1_naa - s1_nab;
      s2_nb  <= s1_nba - s1_nbb;
      s2_v1x <= s1_v1x;
      s2_v1y <= s1_v1y;
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;

      s3_hit <= hit_c;
      s3_dn  <= hit_c ? den_abs[MW-1:0] : '0;
      s3_na  <= hit_c ? na_n[MW-1:0] : '0;
      s3_mx  <= v1x_abs[W-1:0];
      s3_my  <= v1y_abs[W-1:0];
      s3_nx  <= s2_v1x[W];
      s3_ny  <= s2_v1y[W];
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
    end
  end

  assign q_valid = v3;
  assign q_data  = {s3_hit, s3_dn, s3_na, s3_mx, s3_my, s3_nx, s3_ny, s3_ax, s3_ay};

endmodule

// File: hw/rtl/ssi_back.sv
// ----------------------------------------------------------------------------
// ssi_back - crossing point from the classified pair
// Pipelined multiply-divide, one bit of the direction per stage, then round.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssi_back import ssi_pkg::*; #(
  parameter int W  = COORD_BITS_DEF,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [DW-1:0] q_data,
  ssi_out_if.source     result
);

  localparam int CW = 2 * W + 2;
  localparam int MW = CW - 1;
  localparam int TW = MW + 2;

  logic                en;
  logic                bv  [0:W];
  logic                bhit[0:W];
  logic [MW-1:0]       bdn [0:W];
  logic [MW-1:0]       bna [0:W];
  logic [W-1:0]        bmx [0:W];
  logic [W-1:0]        bmy [0:W];
  logic                bnx [0:W];
  logic                bny [0:W];
  logic signed [W-1:0] bax [0:W];
  logic signed [W-1:0] bay [0:W];
  logic [MW-1:0]       brx [0:W];
  logic [MW-1:0]       bry [0:W];
  logic [W-1:0]        bqx [0:W];
  logic [W-1:0]        bqy [0:W];

  logic                in_hit;
  logic [MW-1:0]       in_dn, in_na;
  logic [W-1:0]        in_mx, in_my;
  logic                in_nx, in_ny;
  logic signed [W-1:0] in_ax, in_ay;

  logic signed [W+1:0] px, py;
  logic                out_valid;

  function automatic logic [MW+W-1:0] step(
    input logic [MW-1:0] r,
    input logic [W-1:0]  q,
    input logic          mbit,
    input logic [MW-1:0] na,
    input logic [MW-1:0] dn
  );
    logic [TW-1:0] t;
    logic [TW-1:0] d1;
    logic [TW-1:0] d2;
    logic [1:0]    inc;
    t  = (TW'(r) << 1) + (mbit ? TW'(na) : '0);
    d1 = TW'(dn);
    d2 = TW'(dn) << 1;
    if (t >= d2) begin
      t   = t - d2;
      inc = 2'd2;
    end else if (t >= d1) begin
      t   = t - d1;
      inc = 2'd1;
    end else begin
      inc = 2'd0;
    end
    return {t[MW-1:0], (q << 1) + W'(inc)};
  endfunction

  function automatic logic signed [W+1:0] finish(
    input logic signed [W-1:0] base,
    input logic [W-1:0]        q,
    input logic                neg,
    input logic [MW-1:0]       r
  );
    logic signed [W+1:0] b;
    logic signed [W+1:0] qs;
    logic signed [W+1:0] v;
    b  = (W+2)'(base);
    qs = signed'({2'b00, q});
    v  = neg ? b - qs : b + qs;
    if (r != '0) begin
      if (!neg && v < 0) begin
        v = v + (W+2)'(1);
      end else if (neg && v > 0) begin
        v = v - (W+2)'(1);
      end
    end
    return v;
  endfunction

  assign en      = !out_valid || result.ready;
  assign q_ready = en;

  assign {in_hit, in_dn, in_na, in_mx, in_my, in_nx, in_ny, in_ax, in_ay} = q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv[0] <= 1'b0;
    end else if (en) begin
      bv[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bhit[0] <= in_hit;
      bdn[0]  <= in_dn;
      bna[0]  <= in_na;
      bmx[0]  <= in_mx;
      bmy[0]  <= in_my;
      bnx[0]  <= in_nx;
      bny[0]  <= in_ny;
      bax[0]  <= in_ax;
      bay[0]  <= in_ay;
      brx[0]  <= '0;
      bry[0]  <= '0;
      bqx[0]  <= '0;
      bqy[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        bv[k] <= 1'b0;
      end else if (en) begin
        bv[k] <= bv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bhit[k] <= bhit[k-1];
        bdn[k]  <= bdn[k-1];
        bna[k]  <= bna[k-1];
        bmx[k]  <= bmx[k-1];
        bmy[k]  <= bmy[k-1];
        bnx[k]  <= bnx[k-1];
        bny[k]  <= bny[k-1];
        bax[k]  <= bax[k-1];
        bay[k]  <= bay[k-1];
        {brx[k], bqx[k]} <= step(brx[k-1], bqx[k-1], bmx[k-1][W-k], bna[k-1], bdn[k-1]);
        {bry[k], bqy[k]} <= step(bry[k-1], bqy[k-1], bmy[k-1][W-k], bna[k-1], bdn[k-1]);
      end
    end
  end

  assign px = finish(bax[W], bqx[W], bnx[W], brx[W]);
  assign py = finish(bay[W], bqy[W], bny[W], bry[W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= bv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.hit     <= bhit[W];
      result.cross_x <= bhit[W] ? FIELD_W'(px) : '0;
      result.cross_y <= bhit[W] ? FIELD_W'(py) : '0;
    end
  end

  assign result.valid = out_valid;

endmodule

// File: hw/rtl/segment_segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_segment_intersection - 2-D segment pair crossing test
// Throughput: one pair per cycle; each pipeline stalls only on its own side.
// Front: four stages of differences, cross products and range test.
// Back: one quotient bit per stage over COORD_BITS stages, then rounding.
// Reset: clears valid flags and the queue only; no other state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_segment_intersection import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ssi_in_if.sink    pair,
  ssi_out_if.source result
);

  localparam int CW = 2 * COORD_BITS + 2;
  localparam int DW = 1 + 2 * (CW - 1) + 4 * COORD_BITS + 2;

  logic          f_valid, f_ready;
  logic [DW-1:0] f_data;
  logic          b_valid, b_ready;
  logic [DW-1:0] b_data;

  ssi_front #(.W(COORD_BITS), .DW(DW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .pair    (pair),
    .q_valid (f_valid),
    .q_data  (f_data),
    .q_ready (f_ready)
  );

  ssi_queue #(.DATA_W(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  ssi_back #(.W(COORD_BITS), .DW(DW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_data  (b_data),
    .result  (result)
  );

endmodule
